/* rtl/core/shabs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shabs_pkg
// Types, constants and round functions shared by the SHA-256 byte stream
// hasher modules.
// ----------------------------------------------------------------------------
package shabs_pkg;

	// input item kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	localparam int unsigned WORD_W       = 32;
	localparam int unsigned BLOCK_WORDS  = 16;
	localparam int unsigned ROUNDS       = 64;
	localparam int unsigned DIGEST_WORDS = 8;

	// word slot that carries the high half of the bit length
	localparam logic [3:0] LEN_HI_SLOT = 4'd14;
	localparam logic [7:0] PAD_BYTE    = 8'h80;

	// initial hash value, entry 0 in the low bits
	localparam logic [7:0][31:0] SHA_IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  word_index;
		logic [31:0] digest_word;
		logic        last_word;
	} out_item_t;

	// one message word on its way from the front to the round engine
	typedef struct packed {
		logic        fin;   // last word of the final block of a message
		logic [31:0] word;
	} word_ent_t;

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		sml_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		sml_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [31:0] f_ch(input logic [31:0] e, input logic [31:0] f,
		input logic [31:0] g);
		f_ch = (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] f_maj(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c);
		f_maj = (a & b) ^ (a & c) ^ (b & c);
	endfunction

	// round constants
	function automatic logic [31:0] round_k(input logic [5:0] t);
		logic [31:0] k;
		unique case (t)
			6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
			default: k = 32'h0;
		endcase
		round_k = k;
	endfunction

endpackage
`default_nettype wire

/* rtl/core/shabs_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shabs_front
// Takes data and finish items, packs bytes into big-endian words, counts
// message bits and generates the padding and length words of a message.
// ----------------------------------------------------------------------------
module shabs_front
	import shabs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire in_item_t  item,
	output logic           full,
	output logic           q_wr,
	output word_ent_t      q_data,
	input  wire logic      q_full
);

	localparam logic [1:0] F_DATA = 2'd0;
	localparam logic [1:0] F_PAD1 = 2'd1;
	localparam logic [1:0] F_PADZ = 2'd2;
	localparam logic [1:0] F_LO   = 2'd3;

	logic [1:0]  state_q;
	logic [23:0] acc_q;     // bytes of the partial word, newest in the low byte
	logic [1:0]  byte_q;    // bytes held in acc_q
	logic [3:0]  wcnt_q;    // word slot within the current block
	logic [63:0] bits_q;    // message bit count
	logic [63:0] len_q;     // bit length latched at finish

	logic        accept;
	logic [31:0] pad_word;

	assign full   = (state_q != F_DATA) | q_full;
	assign accept = push & ~full;

	// first padding word: buffered bytes, then the marker byte, then zeros
	always_comb begin
		unique case (byte_q)
			2'd0:    pad_word = {PAD_BYTE, 24'h0};
			2'd1:    pad_word = {acc_q[7:0], PAD_BYTE, 16'h0};
			2'd2:    pad_word = {acc_q[15:0], PAD_BYTE, 8'h0};
			default: pad_word = {acc_q[23:0], PAD_BYTE};
		endcase
	end

	// word stream into the queue
	always_comb begin
		q_wr   = 1'b0;
		q_data = '{fin: 1'b0, word: 32'h0};
		unique case (state_q)
			F_DATA: begin
				q_wr        = accept & (item.kind == KIND_DATA) & (byte_q == 2'd3);
				q_data.word = {acc_q, item.data_byte};
			end
			F_PAD1: begin
				q_wr        = ~q_full;
				q_data.word = pad_word;
			end
			F_PADZ: begin
				q_wr        = ~q_full;
				q_data.word = (wcnt_q == LEN_HI_SLOT) ? len_q[63:32] : 32'h0;
			end
			default: begin
				q_wr        = ~q_full;
				q_data.word = len_q[31:0];
				q_data.fin  = 1'b1;
			end
		endcase
	end

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_DATA;
			byte_q  <= 2'd0;
			wcnt_q  <= 4'd0;
			bits_q  <= 64'd0;
		end else begin
			if (q_wr) wcnt_q <= wcnt_q + 4'd1;
			unique case (state_q)
				F_DATA: begin
					if (accept && item.kind == KIND_DATA) begin
						byte_q <= byte_q + 2'd1;
						bits_q <= bits_q + 64'd8;
					end else if (accept) begin
						bits_q  <= 64'd0;
						state_q <= F_PAD1;
					end
				end
				F_PAD1: begin
					if (q_wr) begin
						byte_q  <= 2'd0;
						state_q <= F_PADZ;
					end
				end
				F_PADZ: begin
					if (q_wr && wcnt_q == LEN_HI_SLOT) state_q <= F_LO;
				end
				default: begin
					if (q_wr) state_q <= F_DATA;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && item.kind == KIND_DATA) acc_q <= {acc_q[15:0], item.data_byte};
		if (accept && item.kind == KIND_FINISH) len_q <= bits_q;
	end

endmodule
`default_nettype wire

/* rtl/core/shabs_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shabs_fifo
// Sixteen-entry word queue between the front and the round engine.
// ----------------------------------------------------------------------------
module shabs_fifo
	import shabs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      wr_en,
	input  wire word_ent_t wr_data,
	output logic           full,
	input  wire logic      rd_en,
	output word_ent_t      rd_data,
	output logic           empty
);

	localparam int unsigned DEPTH = 16;
	localparam int unsigned AW    = $clog2(DEPTH);

	word_ent_t     mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   cnt_q;

	logic do_wr;
	logic do_rd;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) wr_ptr_q <= wr_ptr_q + AW'(1);
			if (do_rd) rd_ptr_q <= rd_ptr_q + AW'(1);
			if (do_wr && !do_rd) cnt_q <= cnt_q + (AW+1)'(1);
			else if (!do_wr && do_rd) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

/* rtl/core/shabs_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shabs_back
// SHA-256 round engine: one round per cycle (stalls while early rounds wait on
// the queue), 16-word schedule window, hash update, digest output register.
// ----------------------------------------------------------------------------
module shabs_back
	import shabs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire word_ent_t q_data,
	input  wire logic      q_empty,
	output logic           q_rd,
	output logic           empty,
	output out_item_t      result,
	input  wire logic      pop
);

	localparam logic B_RUN = 1'b0;
	localparam logic B_ADD = 1'b1;

	logic        state_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic [31:0] v_q   [8];
	logic [31:0] h_q   [8];
	logic [31:0] w_q   [BLOCK_WORDS];
	logic [31:0] dig_q [DIGEST_WORDS];
	logic [2:0]  oidx_q;
	logic        busy_q;

	logic        early;
	logic        step;
	logic        add_go;
	logic        out_pop;
	logic [31:0] wt;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] sum [8];

	// first sixteen rounds take words straight from the queue
	assign early   = (rnd_q < 6'(BLOCK_WORDS));
	assign q_rd    = (state_q == B_RUN) & early & ~q_empty;
	assign step    = (state_q == B_RUN) & (~early | ~q_empty);
	assign add_go  = (state_q == B_ADD) & (~fin_q | ~busy_q);
	assign out_pop = pop & busy_q;

	// schedule word and round sums
	always_comb begin
		if (early) wt = q_data.word;
		else wt = sml_sig1(w_q[14]) + w_q[9] + sml_sig0(w_q[1]) + w_q[0];
		t1 = v_q[7] + big_sig1(v_q[4]) + f_ch(v_q[4], v_q[5], v_q[6]) + round_k(rnd_q) + wt;
		t2 = big_sig0(v_q[0]) + f_maj(v_q[0], v_q[1], v_q[2]);
		for (int i = 0; i < 8; i++) sum[i] = h_q[i] + v_q[i];
	end

	// sequencing, working variables and chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_RUN;
			rnd_q   <= 6'd0;
			fin_q   <= 1'b0;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= SHA_IV[i];
				h_q[i] <= SHA_IV[i];
			end
		end else begin
			unique case (state_q)
				B_RUN: begin
					if (step) begin
						v_q[7] <= v_q[6];
						v_q[6] <= v_q[5];
						v_q[5] <= v_q[4];
						v_q[4] <= v_q[3] + t1;
						v_q[3] <= v_q[2];
						v_q[2] <= v_q[1];
						v_q[1] <= v_q[0];
						v_q[0] <= t1 + t2;
						rnd_q  <= rnd_q + 6'd1;
						if (q_rd) fin_q <= q_data.fin;
						if (rnd_q == 6'(ROUNDS - 1)) state_q <= B_ADD;
					end
				end
				default: begin
					if (add_go) begin
						state_q <= B_RUN;
						for (int i = 0; i < 8; i++) begin
							v_q[i] <= fin_q ? SHA_IV[i] : sum[i];
							h_q[i] <= fin_q ? SHA_IV[i] : sum[i];
						end
					end
				end
			endcase
		end
	end

	// schedule window, newest word at the top
	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < BLOCK_WORDS - 1; i++) w_q[i] <= w_q[i+1];
			w_q[BLOCK_WORDS-1] <= wt;
		end
	end

	// digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			oidx_q <= 3'd0;
		end else begin
			if (add_go && fin_q) begin
				busy_q <= 1'b1;
				oidx_q <= 3'd0;
			end else if (out_pop) begin
				oidx_q <= oidx_q + 3'd1;
				if (oidx_q == 3'(DIGEST_WORDS - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (add_go && fin_q) begin
			for (int i = 0; i < 8; i++) dig_q[i] <= sum[i];
		end
	end

	assign empty              = ~busy_q;
	assign result.word_index  = oidx_q;
	assign result.digest_word = dig_q[oidx_q];
	assign result.last_word   = (oidx_q == 3'(DIGEST_WORDS - 1));

endmodule
`default_nettype wire

/* rtl/core/sha256_byte_stream_hasher_top.sv */
`default_nettype none
// Padding: a finish item holds full while 3 to 18 padding words are queued.
// Throughput: one byte per cycle in bursts while full is low; each 64-byte block
//   takes 64 rounds plus one hash-add step in the round engine.
// Reset: arst_n clears all control state and loads the initial hash value.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream: front packer and padder, word queue, round
// engine with digest output register.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top
	import shabs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	output logic          full,
	output logic          empty,
	output out_item_t     result,
	input  wire logic     pop
);

	logic      q_wr;
	logic      q_full;
	logic      q_rd;
	logic      q_empty;
	word_ent_t q_wdata;
	word_ent_t q_rdata;

	shabs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.q_wr   (q_wr),
		.q_data (q_wdata),
		.q_full (q_full)
	);

	shabs_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	shabs_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_rdata),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.empty   (empty),
		.result  (result),
		.pop     (pop)
	);

	// front never writes into a full queue
	a_no_q_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_wr && q_full))
		else $error("word written into full queue");

	// digest words come out in index order
	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last_word) |=>
		(!empty && result.word_index == $past(result.word_index) + 3'd1))
		else $error("digest word index out of order");

	// taking the last word frees the output
	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && result.last_word) |=> empty)
		else $error("output still busy after last digest word");

	// the last mark sits on the final word only
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.last_word) |-> (result.word_index == 3'd7))
		else $error("last word mark on wrong index");

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SHA-256 byte stream hasher. Byte and finish
// items go in through the push/full side. A SHA-256 model in the bench hashes
// every accepted item and queues the eight digest words that each finish item
// should produce. A checker compares every popped word, field by field, with
// the oldest queued word. Both sides idle at random, apart from a few
// stretches that run at full rate.
// ----------------------------------------------------------------------------
module tb_top;
	import shabs_pkg::*;

	localparam logic [0:7][31:0] START_HASH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] ROUND_K = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam int IDLE_PCT      = 34;
	localparam int MIN_ITEMS     = 250;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 100;
	localparam int MAX_SHOWN     = 10;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	logic      empty;
	logic      pop;
	in_item_t  item;
	out_item_t result;

	// model state: chaining value, message length, partial block
	logic [31:0] chain_val [8];
	logic [63:0] msg_bits;
	logic [7:0]  block_bytes [64];
	int unsigned block_fill;

	out_item_t digest_q [$];
	int        errors;
	int        items_sent;
	bit        quiet;   // no idling on either side while set

	sha256_byte_stream_hasher_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.empty  (empty),
		.result (result),
		.pop    (pop)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// SHA-256 model
	// ------------------------------------------------------------------------
	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// fold the 64 buffered bytes into the chaining value
	function automatic void compress_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1;
		logic [31:0] t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
				block_bytes[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
				(ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		for (int i = 0; i < 8; i++)
			v[i] = chain_val[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_val[i] = chain_val[i] + v[i];
	endfunction

	function automatic void restart_message();
		for (int i = 0; i < 8; i++)
			chain_val[i] = START_HASH[i];
		msg_bits   = '0;
		block_fill = 0;
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		block_bytes[block_fill] = b;
		block_fill++;
		msg_bits = msg_bits + 64'd8;
		if (block_fill == 64) begin
			compress_block();
			block_fill = 0;
		end
	endfunction

	// pad, hash the tail, queue the eight digest words, start over
	function automatic void close_message();
		out_item_t slot;
		block_bytes[block_fill] = 8'h80;
		block_fill++;
		// no room left for the length field: pad out an extra block
		if (block_fill > 56) begin
			while (block_fill < 64) begin
				block_bytes[block_fill] = 8'h00;
				block_fill++;
			end
			compress_block();
			block_fill = 0;
		end
		while (block_fill < 56) begin
			block_bytes[block_fill] = 8'h00;
			block_fill++;
		end
		for (int i = 0; i < 8; i++)
			block_bytes[56+i] = msg_bits[8*(7-i) +: 8];
		compress_block();
		for (int i = 0; i < 8; i++) begin
			slot.word_index  = 3'(i);
			slot.digest_word = chain_val[i];
			slot.last_word   = (i == 7);
			digest_q.push_back(slot);
		end
		restart_message();
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	// drive one item and hold it until accepted; update the model on accept
	task automatic send_item(input logic kind, input logic [7:0] b);
		in_item_t it;
		it.kind      = kind;
		it.data_byte = b;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		if (kind == KIND_DATA)
			absorb_byte(b);
		else
			close_message();
		items_sent++;
	endtask

	task automatic send_message(input int unsigned len);
		for (int i = 0; i < len; i++)
			send_item(KIND_DATA, 8'($urandom_range(255)));
		send_item(KIND_FINISH, 8'($urandom_range(255)));
	endtask

	task automatic test_empty_message();
		send_item(KIND_FINISH, 8'h00);
	endtask

	// each finish in a row hashes the empty message again
	task automatic test_back_to_back_finishes();
		quiet = 1'b1;
		send_item(KIND_FINISH, 8'hff);
		send_item(KIND_FINISH, 8'h5a);
		send_item(KIND_FINISH, 8'($urandom_range(255)));
		quiet = 1'b0;
	endtask

	task automatic test_byte_extremes();
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'hff);
		send_item(KIND_DATA, 8'h01);
		send_item(KIND_DATA, 8'h80);
		send_item(KIND_DATA, 8'h7f);
		send_item(KIND_FINISH, 8'h00);
	endtask

	// last length that fits one pad block, first that needs two, exact block
	task automatic test_padding_boundaries();
		send_message(55);
		send_message(56);
		quiet = 1'b1;
		send_message(64);
		quiet = 1'b0;
	endtask

	// mostly short messages, now and then one that spans two blocks
	task automatic test_random_messages();
		while (items_sent < MIN_ITEMS) begin
			if ($urandom_range(9) == 0)
				send_message($urandom_range(57, 70));
			else
				send_message($urandom_range(0, 40));
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side: random pop, check against the oldest expected word
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		pop <= quiet || ($urandom_range(99) >= IDLE_PCT);
	end

	always @(posedge clk) begin : digest_check
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (digest_q.size() == 0) begin
				errors++;
				if (errors <= MAX_SHOWN)
					$display("unexpected digest word: index %0d word %h last %b",
						result.word_index, result.digest_word, result.last_word);
			end else begin
				want = digest_q.pop_front();
				if (result.word_index !== want.word_index ||
					result.digest_word !== want.digest_word ||
					result.last_word !== want.last_word) begin
					errors++;
					if (errors <= MAX_SHOWN)
						$display("digest mismatch: exp index %0d word %h last %b, got index %0d word %h last %b",
							want.word_index, want.digest_word, want.last_word,
							result.word_index, result.digest_word, result.last_word);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		item       = '0;
		quiet      = 1'b0;
		errors     = 0;
		items_sent = 0;
		restart_message();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_message();
		test_back_to_back_finishes();
		test_byte_extremes();
		test_padding_boundaries();
		test_random_messages();

		// drain outstanding digest words, then watch for stray ones
		quiet = 1'b1;
		@(negedge clk);
		push <= 1'b0;
		for (int n = 0; n < DRAIN_LIMIT && digest_q.size() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (digest_q.size() != 0) begin
			$display("%0d digest words never arrived", digest_q.size());
			errors += digest_q.size();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
`default_nettype wire

/* sim.f */
rtl/core/shabs_pkg.sv
rtl/core/shabs_front.sv
rtl/core/shabs_fifo.sv
rtl/core/shabs_back.sv
rtl/core/sha256_byte_stream_hasher_top.sv
sim/tb_top.sv
